/* hdl/gaussian_puff_point_contribution_macros.svh */
// Assertion macros used by the checker file.
`ifndef GAUSSIAN_PUFF_POINT_CONTRIBUTION_MACROS_SVH
`define GAUSSIAN_PUFF_POINT_CONTRIBUTION_MACROS_SVH

// Checked only outside reset.
`define GPPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define GPPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/gppc_pkg.sv */
package gppc_pkg;
    localparam int COORD_WIDTH       = 24;
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int EXP_BITS          = $clog2(EXP_TABLE_ENTRIES);

    localparam int DIFF_W = COORD_WIDTH + 2;
    localparam int INV_W  = 24;
    localparam int LIM_W  = 23;
    localparam int PRE_W  = 32;
    localparam int PM_W   = DIFF_W + INV_W;
    localparam int U_W    = 28;
    localparam int SQ_W   = 2 * U_W - 1;
    localparam int SUM_W  = SQ_W + 1;
    localparam int A_W    = 21;
    localparam int L2_W   = 33;
    localparam int AP_W   = A_W + L2_W;
    localparam int S_W    = AP_W - 16 + 1;
    localparam int N_W    = S_W - 32;
    localparam int E_W    = 18;
    localparam int OUT_W  = 48;
    localparam int CFG_AW = 2;

    localparam logic [U_W-1:0]   U_SAT     = U_W'(1) << 27;
    localparam logic [L2_W-1:0]  LOG2E_Q32 = 33'd6196328019;
    localparam logic [31:0]      CORR_Q32  = 32'd187593215;
    localparam logic [E_W-1:0]   EXP_ONE   = 18'd131072;

    typedef enum logic [CFG_AW-1:0] {
        REG_SOURCE_X = 2'd0,
        REG_SOURCE_Y = 2'd1,
        REG_SOURCE_Z = 2'd2
    } t_cfg_reg;
endpackage

/* hdl/gaussian_puff_point_contribution.sv */
// Gaussian puff point contribution: one point and its puff-step parameters enter per
// transfer, one result leaves per point. Fully pipelined, eight register stages; a new point
// is taken every cycle while the output is not stalled. The depth comes from the four
// multiplier stages (distance scaling, squaring, exponent scaling, prefactor) and the stages
// around them. A stall at the output holds the whole pipeline. The user must write source
// coordinates on the configuration port while no point is in flight (not enforced).
module gaussian_puff_point_contribution (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gppc_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [gppc_pkg::COORD_WIDTH-1:0] i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_x, point_y, point_z, shift_x, shift_y, inv_sigma_y, inv_sigma_z,
    // xy_limit, z_limit, step_prefactor, zero pad
    input  logic [247:0]                    s_axis_tdata,
    // sigma_valid
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // contribution
    output logic [47:0]                     m_axis_tdata,
    // inside_res
    output logic [0:0]                      m_axis_tuser
);
    import gppc_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic signed [CW-1:0] r_src_x, r_src_y, r_src_z;
    logic [8:1] r_v;
    logic en;

    assign en = !r_v[8] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_x <= '0;
            r_src_y <= '0;
            r_src_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SOURCE_X: r_src_x <= i_cfg_wdata;
                REG_SOURCE_Y: r_src_y <= i_cfg_wdata;
                REG_SOURCE_Z: r_src_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[7:1], s_axis_tvalid};
        end
    end

    // input field unpacking
    logic signed [CW-1:0] px, py, pz, shx, shy;
    logic [INV_W-1:0] inv_y_in, inv_z_in;
    logic [LIM_W-1:0] xyl_in, zl_in;
    logic [PRE_W-1:0] pre_in;
    assign px       = s_axis_tdata[0 +: 24];
    assign py       = s_axis_tdata[24 +: 24];
    assign pz       = s_axis_tdata[48 +: 24];
    assign shx      = s_axis_tdata[72 +: 24];
    assign shy      = s_axis_tdata[96 +: 24];
    assign inv_y_in = s_axis_tdata[120 +: 24];
    assign inv_z_in = s_axis_tdata[144 +: 24];
    assign xyl_in   = s_axis_tdata[168 +: 23];
    assign zl_in    = s_axis_tdata[191 +: 23];
    assign pre_in   = s_axis_tdata[214 +: 32];

    // stage 1: distances
    logic signed [DIFF_W-1:0] r1_dx, r1_dy, r1_dzm, r1_dzp;
    logic [INV_W-1:0] r1_iy, r1_iz;
    logic [LIM_W-1:0] r1_xyl, r1_zl;
    logic [PRE_W-1:0] r1_pre;
    logic r1_sv;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx  <= DIFF_W'(px) - DIFF_W'(r_src_x) - DIFF_W'(shx);
            r1_dy  <= DIFF_W'(py) - DIFF_W'(r_src_y) - DIFF_W'(shy);
            r1_dzm <= DIFF_W'(pz) - DIFF_W'(r_src_z);
            r1_dzp <= DIFF_W'(pz) + DIFF_W'(r_src_z);
            r1_iy  <= inv_y_in;
            r1_iz  <= inv_z_in;
            r1_xyl <= xyl_in;
            r1_zl  <= zl_in;
            r1_pre <= pre_in;
            r1_sv  <= s_axis_tuser[0];
        end
    end

    // stage 2: magnitudes and box test
    logic [DIFF_W-1:0] mx, my, mzm, mzp;
    assign mx  = r1_dx[DIFF_W-1]  ? DIFF_W'(-r1_dx)  : DIFF_W'(r1_dx);
    assign my  = r1_dy[DIFF_W-1]  ? DIFF_W'(-r1_dy)  : DIFF_W'(r1_dy);
    assign mzm = r1_dzm[DIFF_W-1] ? DIFF_W'(-r1_dzm) : DIFF_W'(r1_dzm);
    assign mzp = r1_dzp[DIFF_W-1] ? DIFF_W'(-r1_dzp) : DIFF_W'(r1_dzp);

    logic [DIFF_W-1:0] r2_mx, r2_my, r2_mzm, r2_mzp;
    logic [INV_W-1:0] r2_iy, r2_iz;
    logic [PRE_W-1:0] r2_pre;
    logic r2_in;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_mx  <= mx;
            r2_my  <= my;
            r2_mzm <= mzm;
            r2_mzp <= mzp;
            r2_iy  <= r1_iy;
            r2_iz  <= r1_iz;
            r2_pre <= r1_pre;
            r2_in  <= r1_sv && (mx < DIFF_W'(r1_xyl)) && (my < DIFF_W'(r1_xyl))
                      && (mzm < DIFF_W'(r1_zl));
        end
    end

    // stage 3: scale by inverse sigma
    logic [PM_W-1:0] r3_ux, r3_uy, r3_uzm, r3_uzp;
    logic [PRE_W-1:0] r3_pre;
    logic r3_in;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ux  <= PM_W'(r2_mx) * PM_W'(r2_iy);
            r3_uy  <= PM_W'(r2_my) * PM_W'(r2_iy);
            r3_uzm <= PM_W'(r2_mzm) * PM_W'(r2_iz);
            r3_uzp <= PM_W'(r2_mzp) * PM_W'(r2_iz);
            r3_pre <= r2_pre;
            r3_in  <= r2_in;
        end
    end

    // stage 4: clamp to 8.0 and square
    function automatic logic [U_W-1:0] clamp_u(input logic [PM_W-1:0] u);
        return (u > PM_W'(U_SAT)) ? U_SAT : u[U_W-1:0];
    endfunction

    logic [U_W-1:0] cx, cy, czm, czp;
    assign cx  = clamp_u(r3_ux);
    assign cy  = clamp_u(r3_uy);
    assign czm = clamp_u(r3_uzm);
    assign czp = clamp_u(r3_uzp);

    logic [SQ_W-1:0] r4_sx, r4_sy, r4_szm, r4_szp;
    logic [PRE_W-1:0] r4_pre;
    logic r4_in;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sx  <= SQ_W'(cx) * SQ_W'(cx);
            r4_sy  <= SQ_W'(cy) * SQ_W'(cy);
            r4_szm <= SQ_W'(czm) * SQ_W'(czm);
            r4_szp <= SQ_W'(czp) * SQ_W'(czp);
            r4_pre <= r3_pre;
            r4_in  <= r3_in;
        end
    end

    // stage 5: exponent sums, half taken as Q.16
    logic [SUM_W-1:0] sum_d, sum_r;
    assign sum_d = SUM_W'(r4_sx) + SUM_W'(r4_sy) + SUM_W'(r4_szm);
    assign sum_r = SUM_W'(r4_sx) + SUM_W'(r4_sy) + SUM_W'(r4_szp);

    logic [A_W-1:0] r5_ad, r5_ar;
    logic r5_zd, r5_zr;
    logic [PRE_W-1:0] r5_pre;
    logic r5_in;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ad  <= sum_d[33 +: A_W];
            r5_ar  <= sum_r[33 +: A_W];
            r5_zd  <= |sum_d[SUM_W-1:33+A_W];
            r5_zr  <= |sum_r[SUM_W-1:33+A_W];
            r5_pre <= r4_pre;
            r5_in  <= r4_in;
        end
    end

    // stage 6: convert to base 2
    logic [AP_W-1:0] r6_pd, r6_pr;
    logic r6_zd, r6_zr;
    logic [PRE_W-1:0] r6_pre;
    logic r6_in;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_pd  <= AP_W'(r5_ad) * AP_W'(LOG2E_Q32);
            r6_pr  <= AP_W'(r5_ar) * AP_W'(LOG2E_Q32);
            r6_zd  <= r5_zd;
            r6_zr  <= r5_zr;
            r6_pre <= r5_pre;
            r6_in  <= r5_in;
        end
    end

    // stage 7: power of two with linear mantissa
    function automatic logic [E_W-1:0] pow2_term(input logic [AP_W-1:0] p, input logic zero);
        logic [S_W-1:0] s;
        logic [N_W-1:0] n;
        logic [EXP_BITS-1:0] k;
        logic [E_W-1:0] fq;
        s  = S_W'(p[AP_W-1:16]) + S_W'(CORR_Q32);
        n  = s[S_W-1:32];
        k  = s[31 -: EXP_BITS];
        fq = E_W'({k, 16'b0} >> EXP_BITS);
        if (zero || n > N_W'(16)) begin
            return '0;
        end
        return (EXP_ONE - fq) >> (n + N_W'(1));
    endfunction

    logic [E_W-1:0] r7_td, r7_tr;
    logic [PRE_W-1:0] r7_pre;
    logic r7_in;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_td  <= pow2_term(r6_pd, r6_zd);
            r7_tr  <= pow2_term(r6_pr, r6_zr);
            r7_pre <= r6_pre;
            r7_in  <= r6_in;
        end
    end

    // stage 8: prefactor, saturate, zero points outside the box or without valid sigma
    logic [PRE_W+E_W-1:0] prod;
    assign prod = (PRE_W+E_W)'(r7_pre) * (PRE_W+E_W)'(r7_td + r7_tr);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r7_in) begin
                m_axis_tdata <= '0;
            end else if (|prod[PRE_W+E_W-1:OUT_W]) begin
                m_axis_tdata <= '1;
            end else begin
                m_axis_tdata <= prod[OUT_W-1:0];
            end
            m_axis_tuser <= r7_in;
        end
    end

    assign m_axis_tvalid = r_v[8];
endmodule

/* hdl/gppc_checker.sv */
`include "gaussian_puff_point_contribution_macros.svh"

module gppc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [47:0]                      m_axis_tdata,
    input logic [0:0]                       m_axis_tuser
);
    `GPPC_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
    `GPPC_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
    `GPPC_ASSERT(a_outside_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 48'd0, "nonzero contribution outside box")
    `GPPC_ASSERT(a_backpressure, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while pipeline stalled")
endmodule

bind gaussian_puff_point_contribution gppc_checker u_gppc_checker (.*);
